### design/nat_connection_table_macros.svh
// Assertion macros for the connection table block
`ifndef NAT_CONNECTION_TABLE_MACROS_SVH
`define NAT_CONNECTION_TABLE_MACROS_SVH
// assert that a implies b at the same edge
`define NAT_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("nat: %s failed", "label");
// assert that a implies b at the next edge
`define NAT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("nat: %s failed", "label");
`endif

### design/nat_pkg.sv
// ----------------------------------------------------------------------------
// nat_pkg
// Shared types and constants of the connection table.
// ----------------------------------------------------------------------------
`default_nettype none
package nat_pkg;
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int FORWARD_RULES = 4;
	localparam logic [15:0] TIMEOUT_RESET = 16'd10;
	localparam logic [7:0] ICMP_PROTO_NUM = 8'd1;
	localparam logic [1:0] VERDICT_FWD = 2'd0;
	localparam logic [1:0] VERDICT_NOMATCH = 2'd1;
	localparam logic [1:0] VERDICT_FULL = 2'd2;
	localparam logic [2:0] REG_EXT_IP = 3'd0;
	localparam logic [2:0] REG_INT_IP = 3'd1;
	localparam logic [2:0] REG_TIMEOUT = 3'd2;
	localparam logic [2:0] REG_RULE0 = 3'd3;
	localparam logic [2:0] REG_RULE1 = 3'd4;
	localparam logic [2:0] REG_RULE2 = 3'd5;
	localparam logic [2:0] REG_RULE3 = 3'd6;

	// one table entry as stored
	typedef struct packed {
		logic [15:0] age;
		logic [31:0] remote_ip;
		logic [15:0] remote_port;
		logic [7:0]  protocol;
		logic [31:0] inner_ip;
		logic [15:0] inner_port;
		logic [31:0] outer_ip;
		logic [15:0] outer_port;
	} entry_t;
	localparam int ENTRY_W = $bits(entry_t);

	// compare key for one lookup
	typedef struct packed {
		logic        internal;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [7:0]  proto;
	} key_t;
endpackage
`default_nettype wire

### design/nat_ram.sv
// ----------------------------------------------------------------------------
// nat_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module nat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// registered read; a write returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

### design/nat_match.sv
// ----------------------------------------------------------------------------
// nat_match
// Shared compare unit: tests one stored entry against the lookup key.
// ----------------------------------------------------------------------------
`default_nettype none
module nat_match (
	input  wire nat_pkg::entry_t e,
	input  wire nat_pkg::key_t   k,
	output logic                 hit
);
	import nat_pkg::*;
	// internal side matches inner/remote, external side remote/outer
	always_comb begin
		if (k.internal) begin
			hit = (e.inner_ip == k.sip) && (e.inner_port == k.sp) &&
				(e.remote_ip == k.dip) && (e.remote_port == k.dp) &&
				(e.protocol == k.proto);
		end else begin
			hit = (e.remote_ip == k.sip) && (e.remote_port == k.sp) &&
				(e.outer_ip == k.dip) && (e.outer_port == k.dp) &&
				(e.protocol == k.proto);
		end
	end
endmodule
`default_nettype wire

### design/nat_connection_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nat_connection_table
// Source/destination NAT with a sixteen-entry connection table.
// ----------------------------------------------------------------------------
// Use: pulse start with the packet or tick fields while busy is low; the word
// is taken at that edge and busy rises. A packet walks the table one entry a
// cycle through a single compare unit reading the entry RAM, then writes the
// hit or new entry back unless dropped. Tick items read each entry in turn,
// writing back decremented ages and freeing expired entries. A packet holds
// busy through scan, decision and, unless dropped, write; a tick through a
// read and a write-back state per entry. A packet gives one result word,
// shown with done high for one cycle as busy falls; a tick gives none. The
// receiver cannot stall. Registers sit on an APB port, each at 8*index; the
// user must write them only while idle, which the block does not enforce.
// Reset clears valid bits and resets registers; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module nat_connection_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        mode,
	input  wire logic [31:0] src_ip,
	input  wire logic [31:0] dst_ip,
	input  wire logic [15:0] src_port,
	input  wire logic [15:0] dst_port,
	input  wire logic [7:0]  protocol,
	input  wire logic [15:0] icmp_id,
	output logic             done,
	output logic      [1:0]  verdict,
	output logic      [31:0] out_src_ip,
	output logic      [31:0] out_dst_ip,
	output logic      [15:0] out_src_port,
	output logic      [15:0] out_dst_port,
	output logic             created
);
	import nat_pkg::*;
	`include "nat_connection_table_macros.svh"

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DEC   = 3'd2;
	localparam logic [2:0] ST_RULE  = 3'd3;
	localparam logic [2:0] ST_WRITE = 3'd4;
	localparam logic [2:0] ST_TREAD = 3'd5;
	localparam logic [2:0] ST_TWR   = 3'd6;

	logic [2:0] state_q;
	logic [31:0] ext_ip_q, int_ip_q;
	logic [15:0] timeout_q;
	logic [63:0] rule_q [FORWARD_RULES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	// captured packet
	logic [31:0] sip_q, dip_q;
	logic [15:0] sp_raw_q, dp_raw_q;
	key_t key_q;

	// scan control
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             rd_vld_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	entry_t           hit_e_q;

	// RAM port
	logic         ram_we;
	logic [IDX_W-1:0] ram_addr;
	entry_t       ram_wdata, ram_rdata;

	nat_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	logic cmp_hit;
	nat_match u_match (.e(ram_rdata), .k(key_q), .hit(cmp_hit));

	// APB
	logic       wr_en;
	logic [2:0] reg_idx;
	assign pready = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr_en = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx)
			REG_EXT_IP:  prdata = {32'd0, ext_ip_q};
			REG_INT_IP:  prdata = {32'd0, int_ip_q};
			REG_TIMEOUT: prdata = {48'd0, timeout_q};
			REG_RULE0:   prdata = rule_q[0];
			REG_RULE1:   prdata = rule_q[1];
			REG_RULE2:   prdata = rule_q[2];
			REG_RULE3:   prdata = rule_q[3];
			default:     prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_ip_q  <= '0;
			int_ip_q  <= '0;
			timeout_q <= TIMEOUT_RESET;
			for (int r = 0; r < FORWARD_RULES; r++) rule_q[r] <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_EXT_IP:  ext_ip_q  <= pwdata[31:0];
				REG_INT_IP:  int_ip_q  <= pwdata[31:0];
				REG_TIMEOUT: timeout_q <= pwdata[15:0];
				REG_RULE0:   rule_q[0] <= pwdata;
				REG_RULE1:   rule_q[1] <= pwdata;
				REG_RULE2:   rule_q[2] <= pwdata;
				REG_RULE3:   rule_q[3] <= pwdata;
				default:     ;
			endcase
		end
	end

	// lowest free slot and rule priority
	logic             free_any;
	logic [IDX_W-1:0] free_idx;
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	logic        rule_any;
	logic [63:0] rule_sel;
	always_comb begin
		rule_any = 1'b0;
		rule_sel = '0;
		for (int r = FORWARD_RULES - 1; r >= 0; r--) begin
			if (rule_q[r][63:48] != 16'd0 && rule_q[r][63:48] == dp_raw_q) begin
				rule_any = 1'b1;
				rule_sel = rule_q[r];
			end
		end
	end

	// new, refreshed and decremented entry words
	entry_t new_int_e, new_ext_e, upd_e, dec_e;
	always_comb begin
		new_int_e = '{age: timeout_q, remote_ip: dip_q, remote_port: key_q.dp,
			protocol: key_q.proto, inner_ip: sip_q, inner_port: key_q.sp,
			outer_ip: ext_ip_q, outer_port: key_q.sp};
		new_ext_e = '{age: timeout_q, remote_ip: sip_q, remote_port: key_q.sp,
			protocol: key_q.proto, inner_ip: rule_sel[31:0],
			inner_port: rule_sel[47:32], outer_ip: dip_q, outer_port: key_q.dp};
		upd_e = hit_e_q;
		upd_e.age = timeout_q;
		dec_e = ram_rdata;
		dec_e.age = ram_rdata.age - 16'd1;
	end

	// RAM address and write select
	always_comb begin
		ram_we = 1'b0;
		ram_wdata = upd_e;
		ram_addr = cnt_q[IDX_W-1:0];
		unique case (state_q)
			ST_WRITE: begin
				ram_addr = hit_idx_q;
				ram_we = 1'b1;
				if (hit_q) ram_wdata = upd_e;
				else if (key_q.internal) ram_wdata = new_int_e;
				else ram_wdata = new_ext_e;
			end
			ST_TWR: begin
				ram_addr = rd_idx_q;
				ram_wdata = dec_e;
				ram_we = valid_q[rd_idx_q] && ram_rdata.age > 16'd1;
			end
			default: ;
		endcase
	end

	logic [15:0] sp_eff;
	assign sp_eff = (protocol == ICMP_PROTO_NUM) ? icmp_id : src_port;
	assign busy = (state_q != ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_q  <= '0;
			cnt_q    <= '0;
			rd_vld_q <= 1'b0;
			hit_q    <= 1'b0;
			done     <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						rd_vld_q <= 1'b0;
						hit_q <= 1'b0;
						state_q <= mode ? ST_TREAD : ST_SCAN;
					end
				end
				// one read issued and one compared per cycle
				ST_SCAN: begin
					rd_idx_q <= cnt_q[IDX_W-1:0];
					rd_vld_q <= (cnt_q < CNT_W'(TABLE_ENTRIES));
					if (cnt_q < CNT_W'(TABLE_ENTRIES)) cnt_q <= cnt_q + 1'b1;
					if (rd_vld_q && !hit_q && valid_q[rd_idx_q] && cmp_hit) begin
						hit_q <= 1'b1;
						hit_idx_q <= rd_idx_q;
						hit_e_q <= ram_rdata;
					end
					if (!rd_vld_q && cnt_q == CNT_W'(TABLE_ENTRIES))
						state_q <= ST_DEC;
				end
				ST_DEC: begin
					state_q <= ST_IDLE;
					done <= 1'b1;
					created <= 1'b0;
					verdict <= VERDICT_FWD;
					out_src_ip <= sip_q;
					out_dst_ip <= dip_q;
					out_src_port <= sp_raw_q;
					out_dst_port <= dp_raw_q;
					if (hit_q) begin
						state_q <= ST_WRITE;
						done <= 1'b0;
					end else if (!key_q.internal && !rule_any) begin
						verdict <= VERDICT_NOMATCH;
					end else if (!free_any) begin
						verdict <= VERDICT_FULL;
					end else begin
						hit_idx_q <= free_idx;
						state_q <= ST_WRITE;
						done <= 1'b0;
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
					done <= 1'b1;
					valid_q[hit_idx_q] <= 1'b1;
					created <= !hit_q;
					if (key_q.internal) begin
						out_src_ip <= hit_q ? hit_e_q.outer_ip : ext_ip_q;
						out_src_port <= hit_q ? hit_e_q.outer_port : key_q.sp;
					end else begin
						out_dst_ip <= hit_q ? hit_e_q.inner_ip : rule_sel[31:0];
						out_dst_port <= hit_q ? hit_e_q.inner_port : rule_sel[47:32];
					end
				end
				// tick: read each entry, then write back its decremented age if it survives
				ST_TREAD: begin
					rd_idx_q <= cnt_q[IDX_W-1:0];
					if (cnt_q == CNT_W'(TABLE_ENTRIES)) state_q <= ST_IDLE;
					else state_q <= ST_TWR;
				end
				ST_TWR: begin
					if (valid_q[rd_idx_q] && ram_rdata.age <= 16'd1)
						valid_q[rd_idx_q] <= 1'b0;
					cnt_q <= cnt_q + 1'b1;
					state_q <= ST_TREAD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture the packet
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			sip_q <= src_ip;
			dip_q <= dst_ip;
			sp_raw_q <= src_port;
			dp_raw_q <= dst_port;
			key_q <= '{internal: (src_ip == int_ip_q), sip: src_ip, dip: dst_ip,
				sp: sp_eff, dp: (protocol == ICMP_PROTO_NUM) ? icmp_id : dst_port,
				proto: protocol};
		end
	end

	`NAT_ASSERT_IMP(a_done_idle, clk, arst_n, done, state_q == ST_IDLE)
	`NAT_ASSERT_IMP(a_created_fwd, clk, arst_n, done && created, verdict == VERDICT_FWD)
	`NAT_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the NAT connection table: directed packets and a tick, then random
// flows of internal/external traffic under varied registers and rules, against
// a cycle-free predictor of the table kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
	import nat_pkg::*;

	localparam int LIMIT = 2000000;

	// one packet or tick word
	typedef struct {
		logic        mode;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [7:0]  proto;
		logic [15:0] id;
	} pkt_t;

	// one translated result word
	typedef struct {
		logic [1:0]  verdict;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sp;
		logic [15:0] dp;
		logic        created;
	} xlat_t;

	// predicted table plus queue of pending translations
	class nat_scoreboard;
		logic [31:0] ext_addr, int_addr;
		logic [15:0] age_load;
		logic [63:0] rules [FORWARD_RULES];
		bit          vld [TABLE_ENTRIES];
		logic [15:0] age [TABLE_ENTRIES];
		logic [31:0] r_ip [TABLE_ENTRIES], i_ip [TABLE_ENTRIES], o_ip [TABLE_ENTRIES];
		logic [15:0] r_pt [TABLE_ENTRIES], i_pt [TABLE_ENTRIES], o_pt [TABLE_ENTRIES];
		logic [7:0]  prot [TABLE_ENTRIES];
		xlat_t       pending [$];
		int          errors;

		function new();
			ext_addr = 32'h0;
			int_addr = 32'h0;
			age_load = TIMEOUT_RESET;
			foreach (rules[r]) rules[r] = 64'h0;
			foreach (vld[i]) vld[i] = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [63:0] v);
			case (idx) inside
				REG_EXT_IP: ext_addr = v[31:0];
				REG_INT_IP: int_addr = v[31:0];
				REG_TIMEOUT: age_load = v[15:0];
				REG_RULE0, REG_RULE1, REG_RULE2, REG_RULE3: rules[idx - REG_RULE0] = v;
				default: ;
			endcase
		endfunction

		function int lowest_free();
			for (int i = 0; i < TABLE_ENTRIES; i++)
				if (!vld[i]) return i;
			return -1;
		endfunction

		function void fill(int i, logic [31:0] rip, logic [15:0] rp, logic [7:0] pr,
				logic [31:0] iip, logic [15:0] ip, logic [31:0] oip, logic [15:0] op);
			vld[i] = 1'b1; age[i] = age_load;
			r_ip[i] = rip; r_pt[i] = rp; prot[i] = pr;
			i_ip[i] = iip; i_pt[i] = ip; o_ip[i] = oip; o_pt[i] = op;
		endfunction

		// note an accepted word and predict its result
		function void note_input(pkt_t p);
			logic [15:0] sp, dp;
			xlat_t x;
			int hit, rule;
			hit = -1;
			rule = -1;
			if (p.mode) begin
				for (int i = 0; i < TABLE_ENTRIES; i++)
					if (vld[i]) begin
						if (age[i] <= 16'd1) vld[i] = 1'b0;
						else age[i] = age[i] - 16'd1;
					end
				return;
			end
			sp = (p.proto == ICMP_PROTO_NUM) ? p.id : p.sp;
			dp = (p.proto == ICMP_PROTO_NUM) ? p.id : p.dp;
			x = '{VERDICT_FWD, p.sip, p.dip, p.sp, p.dp, 1'b0};
			if (p.sip == int_addr) begin
				for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
					if (vld[i] && i_ip[i] == p.sip && i_pt[i] == sp && r_ip[i] == p.dip &&
							r_pt[i] == dp && prot[i] == p.proto)
						hit = i;
				if (hit >= 0) begin
					age[hit] = age_load;
					x.sip = o_ip[hit];
					x.sp = o_pt[hit];
				end else begin
					hit = lowest_free();
					if (hit < 0) x.verdict = VERDICT_FULL;
					else begin
						fill(hit, p.dip, dp, p.proto, p.sip, sp, ext_addr, sp);
						x.created = 1'b1;
						x.sip = ext_addr;
						x.sp = sp;
					end
				end
			end else begin
				for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
					if (vld[i] && r_ip[i] == p.sip && r_pt[i] == sp && o_ip[i] == p.dip &&
							o_pt[i] == dp && prot[i] == p.proto)
						hit = i;
				if (hit >= 0) begin
					age[hit] = age_load;
					x.dip = i_ip[hit];
					x.dp = i_pt[hit];
				end else begin
					for (int r = 0; r < FORWARD_RULES && rule < 0; r++)
						if (rules[r][63:48] != 16'h0 && rules[r][63:48] == p.dp) rule = r;
					if (rule < 0) x.verdict = VERDICT_NOMATCH;
					else begin
						hit = lowest_free();
						if (hit < 0) x.verdict = VERDICT_FULL;
						else begin
							fill(hit, p.sip, sp, p.proto, rules[rule][31:0],
								rules[rule][47:32], p.dip, dp);
							x.created = 1'b1;
							x.dip = rules[rule][31:0];
							x.dp = rules[rule][47:32];
						end
					end
				end
			end
			pending.insert(pending.size(), x);
		endfunction

		// compare one result word with the oldest prediction
		function void check_result(xlat_t a);
			xlat_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word verdict=%0d", $time, a.verdict);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.verdict !== e.verdict) begin
				$display("%0t: verdict exp %0d got %0d", $time, e.verdict, a.verdict);
				errors++;
			end
			if (a.sip !== e.sip) begin
				$display("%0t: out_src_ip exp %h got %h", $time, e.sip, a.sip);
				errors++;
			end
			if (a.dip !== e.dip) begin
				$display("%0t: out_dst_ip exp %h got %h", $time, e.dip, a.dip);
				errors++;
			end
			if (a.sp !== e.sp) begin
				$display("%0t: out_src_port exp %h got %h", $time, e.sp, a.sp);
				errors++;
			end
			if (a.dp !== e.dp) begin
				$display("%0t: out_dst_port exp %h got %h", $time, e.dp, a.dp);
				errors++;
			end
			if (a.created !== e.created) begin
				$display("%0t: created exp %0d got %0d", $time, e.created, a.created);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata, prdata;
	logic        pready;
	logic        start, busy, mode;
	logic [31:0] src_ip, dst_ip;
	logic [15:0] src_port, dst_port, icmp_id;
	logic [7:0]  protocol;
	logic        done, created;
	logic [1:0]  verdict;
	logic [31:0] out_src_ip, out_dst_ip;
	logic [15:0] out_src_port, out_dst_port;

	nat_scoreboard sb;
	int            cycles;
	logic [31:0]   pool_ip [4];
	logic [15:0]   pool_pt [4];
	logic [7:0]    pool_pr [3];
	logic [15:0]   rule_key [FORWARD_RULES];

	nat_connection_table dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// result monitor and run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done)
			sb.check_result('{verdict, out_src_ip, out_dst_ip, out_src_port,
				out_dst_port, created});
		if (cycles > LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic idle(int n);
		repeat (n) @(posedge clk);
	endtask

	task automatic rand_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 40) return;
		else if (k < 95) idle($urandom_range(1, 4));
		else idle($urandom_range(20, 80));
	endtask

	task automatic reg_write(logic [2:0] idx, logic [63:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.write_reg(idx, v);
		@(posedge clk);
	endtask

	// send one word; start drops in the cycle after acceptance
	task automatic send(pkt_t p);
		start <= 1; mode <= p.mode; src_ip <= p.sip; dst_ip <= p.dip;
		src_port <= p.sp; dst_port <= p.dp; protocol <= p.proto; icmp_id <= p.id;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_input(p);
		start <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		idle(2 * TABLE_ENTRIES + 8);
	endtask

	function automatic pkt_t mk(logic m, logic [31:0] s, logic [31:0] d, logic [15:0] a,
			logic [15:0] b, logic [7:0] pr, logic [15:0] id);
		mk = '{m, s, d, a, b, pr, id};
	endfunction

	// flows drawn from small pools so lookups hit often
	function automatic pkt_t rand_pkt();
		pkt_t p;
		int k;
		k = $urandom_range(0, 99);
		p = mk(1'b0, $urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
			16'($urandom));
		if (k < 8) begin
			p.mode = 1'b1;
			return p;
		end
		if (k < 15) return p;
		p.proto = (k % 5 == 0) ? ICMP_PROTO_NUM : pool_pr[$urandom_range(0, 2)];
		p.id = pool_pt[$urandom_range(0, 3)];
		if (k < 55) begin
			p.sip = sb.int_addr;
			p.sp = pool_pt[$urandom_range(0, 3)];
			p.dip = pool_ip[$urandom_range(0, 3)];
			p.dp = pool_pt[$urandom_range(0, 3)];
		end else begin
			p.sip = pool_ip[$urandom_range(0, 3)];
			p.sp = pool_pt[$urandom_range(0, 3)];
			p.dip = $urandom_range(0, 1) ? sb.ext_addr : pool_ip[$urandom_range(0, 3)];
			p.dp = (k < 80) ? rule_key[$urandom_range(0, FORWARD_RULES - 1)]
				: pool_pt[$urandom_range(0, 3)];
		end
		return p;
	endfunction

	task automatic setup_phase(int ph);
		logic [31:0] e, i;
		logic [15:0] t;
		e = (ph == 0) ? 32'hFFFF_FFFF : (ph == 1) ? 32'h0 : $urandom;
		i = (ph == 0) ? 32'h0 : (ph == 1) ? 32'hFFFF_FFFF : $urandom;
		t = (ph == 0) ? 16'd1 : (ph == 1) ? 16'hFFFF : (ph == 2) ? 16'd0
			: 16'($urandom_range(2, 40));
		reg_write(REG_EXT_IP, {32'h0, e});
		reg_write(REG_INT_IP, {32'h0, i});
		reg_write(REG_TIMEOUT, {48'h0, t});
		foreach (pool_ip[k]) pool_ip[k] = $urandom;
		foreach (pool_pt[k]) pool_pt[k] = (k == 0) ? 16'hFFFF : 16'($urandom);
		pool_pr[0] = 8'hFF;
		pool_pr[1] = 8'd6;
		pool_pr[2] = 8'($urandom);
		for (int r = 0; r < FORWARD_RULES; r++) begin
			rule_key[r] = (r == 3 && ph == 0) ? 16'd0 : pool_pt[$urandom_range(0, 3)];
			reg_write(3'(REG_RULE0 + r), {rule_key[r], 16'($urandom), 32'($urandom)});
		end
	endtask

	initial begin
		sb = new();
		cycles = 0;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		start = 0; mode = 0; src_ip = 0; dst_ip = 0; src_port = 0; dst_port = 0;
		protocol = 0; icmp_id = 0;
		idle(4);
		arst_n <= 1;
		idle(2);

		// directed: reset registers, no rules, internal flows to fill the table
		send(mk(1'b0, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 8'hFF, 16'hFFFF));
		send(mk(1'b0, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 8'hFF, 16'h0));
		send(mk(1'b0, 32'h1, 32'h0, 16'h0, 16'h0, 8'd6, 16'h0));
		send(mk(1'b0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 8'd6, 16'h0));
		for (int k = 0; k < 16; k++)
			send(mk(1'b0, 32'h0, 32'h0A00_0000 + k, 16'(k), 16'h50, ICMP_PROTO_NUM,
				16'(k)));
		send(mk(1'b0, 32'h0, 32'h0A00_0000, 16'h7, 16'h50, ICMP_PROTO_NUM, 16'h0));
		send(mk(1'b0, 32'h0, 32'h0B00_0000, 16'h7, 16'h50, 8'd17, 16'h0));
		send(mk(1'b0, 32'h0A00_0003, 32'h0, 16'h1, 16'h1, ICMP_PROTO_NUM, 16'h3));
		send(mk(1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 16'h0));
		drain();

		// phases with distinct register settings; ticks age the table out
		for (int ph = 0; ph < 6; ph++) begin
			setup_phase(ph);
			repeat (12) send(mk(1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 16'h0));
			for (int n = 0; n < 270; n++) begin
				send(rand_pkt());
				if ($urandom_range(0, 9) < 7) rand_gap();
				if (n == 135) drain();
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
`default_nettype wire
